/* hdl/pom_pkg.sv */
package pom_pkg;

    localparam int VOICES = 16;
    localparam int VOICE_W = $clog2(VOICES);
    localparam int COUNT_W = $clog2(VOICES + 1);
    localparam int SAMPLE_RATE = 48000;
    localparam int PHASE_BITS = 24;
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SINE_W = $clog2(SINE_TABLE_DEPTH);
    localparam int SUM_W = 36;
    localparam int QUOT_W = 20;
    localparam int DIV_CNT_W = $clog2(QUOT_W + 1);

    localparam logic [31:0] LFSR_SEED = 32'h0000_ACE1;
    localparam logic [31:0] LFSR_MASK = 32'h8020_0003;
    localparam logic [63:0] GAIN_RATIO_Q30 = 64'd1045045415;
    localparam logic [63:0] SC1 = 64'd1686629713;
    localparam logic [63:0] SC3 = 64'd693598668;
    localparam logic [63:0] SC5 = 64'd85569306;
    localparam logic [63:0] SC7 = 64'd5026995;
    localparam logic [63:0] SC9 = 64'd172273;
    localparam logic [63:0] INC_DEN = 64'd65536 * 64'(SAMPLE_RATE);

    localparam logic [2:0] WAVE_SINE = 3'd0;
    localparam logic [2:0] WAVE_SAW = 3'd1;
    localparam logic [2:0] WAVE_SQUARE = 3'd2;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd3;
    localparam logic [2:0] WAVE_NOISE = 3'd4;

    localparam logic REQ_SET = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef logic [PHASE_BITS-1:0] inc_rom_t [128];
    typedef logic [15:0] gain_rom_t [256];
    typedef logic signed [15:0] sine_rom_t [SINE_TABLE_DEPTH];

    localparam logic [63:0] SEMITONE_HZ_Q16 [12] = '{
        64'd17145893, 64'd18165441, 64'd19245614, 64'd20390018,
        64'd21602472, 64'd22887021, 64'd24247954, 64'd25689813,
        64'd27217409, 64'd28835840, 64'd30550508, 64'd32367136
    };

    function automatic inc_rom_t build_inc_rom();
        inc_rom_t rom;
        logic [63:0] num;
        int oct;
        int semi;
        for (int n = 0; n < 128; n++) begin
            oct = n / 12;
            semi = n % 12;
            num = SEMITONE_HZ_Q16[semi] << (PHASE_BITS + oct - 5);
            rom[n] = PHASE_BITS'((num + INC_DEN / 2) / INC_DEN);
        end
        return rom;
    endfunction

    function automatic gain_rom_t build_gain_rom();
        gain_rom_t rom;
        logic [63:0] g;
        logic [63:0] q;
        g = 64'd1 << 30;
        for (int v = 255; v >= 1; v--) begin
            q = (g + 64'd16384) >> 15;
            if (q > 64'd32767) begin
                q = 64'd32767;
            end
            rom[v] = q[15:0];
            g = (g * GAIN_RATIO_Q30 + (64'd1 << 29)) >> 30;
        end
        rom[0] = 16'd0;
        return rom;
    endfunction

    function automatic logic [15:0] quarter_sine(logic [63:0] t);
        logic [63:0] t2;
        logic [63:0] p;
        logic [63:0] r;
        logic [63:0] q;
        t2 = (t * t) >> 30;
        p = SC9;
        p = SC7 - ((p * t2) >> 30);
        p = SC5 - ((p * t2) >> 30);
        p = SC3 - ((p * t2) >> 30);
        p = SC1 - ((p * t2) >> 30);
        r = (p * t) >> 30;
        q = (r + 64'd16384) >> 15;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return q[15:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        logic [63:0] a;
        logic [63:0] u;
        logic [63:0] t;
        logic [15:0] s;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            a = (64'(i) << 32) / 64'(SINE_TABLE_DEPTH);
            u = a & 64'h3FFF_FFFF;
            t = a[30] ? ((64'd1 << 30) - u) : u;
            s = quarter_sine(t);
            rom[i] = a[31] ? -$signed(s) : $signed(s);
        end
        return rom;
    endfunction

    localparam inc_rom_t INC_ROM = build_inc_rom();
    localparam gain_rom_t GAIN_ROM = build_gain_rom();
    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

/* hdl/polyphonic_oscillator_mixer.sv */
// Channel  | Handshake          | Words
// s_       | s_valid / s_ready  | req_type, voice, active, midi_note, waveform, volume
// m_       | m_valid / m_ready  | sample, voices_active
//
// A voice-set word is applied in the idle state. A tick word steps each voice in turn
// through the shared multiplier and accumulator, then a restoring divider with a
// 20-bit quotient forms the mean, after the drain and prep states and before done.
// Reset is synchronous and active low; it turns all voices off and reseeds noise.
// A waiting result does not block new words; a finished tick waits for a free output.
module polyphonic_oscillator_mixer
    import pom_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic [3:0]         s_voice,
    input  logic               s_active,
    input  logic [6:0]         s_midi_note,
    input  logic [2:0]         s_waveform,
    input  logic [7:0]         s_volume,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_sample,
    output logic [4:0]         m_voices_active
);

    state_t state_reg, state_next;

    logic [PHASE_BITS-1:0] phase_reg [VOICES];
    logic [PHASE_BITS-1:0] inc_reg [VOICES];
    logic [2:0]            shape_reg [VOICES];
    logic [15:0]           gain_reg [VOICES];
    logic [VOICES-1:0]     on_reg;
    logic [31:0]           lfsr_reg;

    logic [VOICE_W-1:0]    vidx_reg;
    logic signed [31:0]    prod_reg;
    logic                  prod_ok_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [QUOT_W-1:0]     num_reg;
    logic [COUNT_W-1:0]    rem_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;
    logic                  m_valid_reg;
    logic signed [15:0]    m_sample_reg;
    logic [4:0]            m_count_reg;

    logic                  s_fire;
    logic                  out_free;
    logic                  scan_last;
    logic                  div_last;
    logic [PHASE_BITS-1:0] cur_phase;
    logic [15:0]           p16;
    logic [31:0]           lfsr_step;
    logic signed [17:0]    tri_raw;
    logic signed [15:0]    wave;
    logic [SUM_W-1:0]      mag;
    logic [SUM_W-1:0]      rounded;
    logic [COUNT_W:0]      rem_sh;
    logic                  rem_ge;
    logic [QUOT_W-1:0]     q_cap;
    logic signed [15:0]    smp;

    assign s_fire = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign scan_last = (vidx_reg == VOICE_W'(VOICES - 1));
    assign div_last = (div_cnt_reg == DIV_CNT_W'(QUOT_W - 1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_req_type == REQ_TICK) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_PREP;
            ST_PREP:  state_next = ST_DIV;
            ST_DIV: begin
                if (div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == ST_IDLE);
    end

    // One voice per cycle: waveform and gain product.
    always_comb begin
        cur_phase = phase_reg[vidx_reg];
        p16 = cur_phase[PHASE_BITS-1 -: 16];
        lfsr_step = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_MASK : 32'd0);
        tri_raw = p16[15] ? (18'sd98304 - $signed({1'b0, p16, 1'b0}))
                          : ($signed({1'b0, p16, 1'b0}) - 18'sd32768);
        case (shape_reg[vidx_reg])
            WAVE_SINE:     wave = SINE_ROM[cur_phase[PHASE_BITS-1 -: SINE_W]];
            WAVE_SAW:      wave = $signed({~p16[15], p16[14:0]});
            WAVE_SQUARE:   wave = p16[15] ? -16'sd32768 : 16'sd32767;
            WAVE_TRIANGLE: wave = (tri_raw > 18'sd32767) ? 16'sd32767 : tri_raw[15:0];
            WAVE_NOISE:    wave = $signed({~lfsr_step[31], lfsr_step[30:16]});
            default:       wave = 16'sd0;
        endcase
    end

    always_comb begin
        mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        rounded = mag + (SUM_W'(count_reg) << 14);
        rem_sh = {rem_reg, num_reg[QUOT_W-1]};
        rem_ge = (rem_sh >= {1'b0, count_reg});
        q_cap = (num_reg > QUOT_W'(32768)) ? QUOT_W'(32768) : num_reg;
        if (count_reg == '0) begin
            smp = 16'sd0;
        end else if (sum_reg[SUM_W-1]) begin
            smp = 16'(-$signed({1'b0, q_cap}));
        end else if (q_cap > QUOT_W'(32767)) begin
            smp = 16'sd32767;
        end else begin
            smp = $signed(q_cap[15:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            on_reg <= '0;
            lfsr_reg <= LFSR_SEED;
            m_valid_reg <= 1'b0;
            vidx_reg <= '0;
            prod_ok_reg <= 1'b0;
            div_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    vidx_reg <= '0;
                    prod_ok_reg <= 1'b0;
                    sum_reg <= '0;
                    count_reg <= '0;
                    if (s_fire && s_req_type == REQ_SET) begin
                        if (!s_active) begin
                            on_reg[s_voice] <= 1'b0;
                        end else begin
                            if (!on_reg[s_voice]) begin
                                phase_reg[s_voice] <= '0;
                            end
                            on_reg[s_voice] <= 1'b1;
                            inc_reg[s_voice] <= INC_ROM[s_midi_note];
                            shape_reg[s_voice] <= s_waveform;
                            gain_reg[s_voice] <= GAIN_ROM[s_volume];
                        end
                    end
                end
                ST_SCAN: begin
                    vidx_reg <= vidx_reg + 1'b1;
                    if (prod_ok_reg) begin
                        sum_reg <= sum_reg + SUM_W'(prod_reg);
                    end
                    prod_ok_reg <= on_reg[vidx_reg];
                    if (on_reg[vidx_reg]) begin
                        prod_reg <= $signed({1'b0, gain_reg[vidx_reg]}) * wave;
                        phase_reg[vidx_reg] <= cur_phase + inc_reg[vidx_reg];
                        count_reg <= count_reg + 1'b1;
                        if (shape_reg[vidx_reg] == WAVE_NOISE) begin
                            lfsr_reg <= lfsr_step;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (prod_ok_reg) begin
                        sum_reg <= sum_reg + SUM_W'(prod_reg);
                    end
                    prod_ok_reg <= 1'b0;
                end
                ST_PREP: begin
                    num_reg <= rounded[15 +: QUOT_W];
                    rem_reg <= '0;
                    div_cnt_reg <= '0;
                end
                ST_DIV: begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    rem_reg <= rem_ge ? COUNT_W'(rem_sh - {1'b0, count_reg})
                                      : rem_sh[COUNT_W-1:0];
                    num_reg <= {num_reg[QUOT_W-2:0], rem_ge};
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_sample_reg <= smp;
                        m_count_reg <= 5'(count_reg);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_sample = m_sample_reg;
    assign m_voices_active = m_count_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_voices_active <= 5'(VOICES)))
        else $error("voice count out of range");

    a_silent_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_voices_active == 5'd0) |-> (m_sample == 16'sd0))
        else $error("nonzero sample with no voices");

    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_req_type == REQ_TICK) |=> !s_ready)
        else $error("ready while a tick is in progress");

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;
    import pom_pkg::*;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_req_type;
    logic [3:0]         s_voice;
    logic               s_active;
    logic [6:0]         s_midi_note;
    logic [2:0]         s_waveform;
    logic [7:0]         s_volume;
    logic               m_valid;
    logic               m_ready;
    logic signed [15:0] m_sample;
    logic [4:0]         m_voices_active;

    polyphonic_oscillator_mixer u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_voice        (s_voice),
        .s_active       (s_active),
        .s_midi_note    (s_midi_note),
        .s_waveform     (s_waveform),
        .s_volume       (s_volume),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample       (m_sample),
        .m_voices_active(m_voices_active)
    );

    typedef struct packed {
        logic       req_type;
        logic [3:0] voice;
        logic       active;
        logic [6:0] midi_note;
        logic [2:0] waveform;
        logic [7:0] volume;
    } voice_word_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [4:0]         voices_active;
    } mix_word_t;

    typedef struct packed {
        voice_word_t word;
        logic        has_known;
        mix_word_t   known;
    } stim_row_t;

    localparam int RANDOM_WORDS = 1030;
    localparam longint CYCLE_LIMIT = 1000000;

    logic [PHASE_BITS-1:0] osc_phase [VOICES];
    logic                  osc_on [VOICES];
    logic [PHASE_BITS-1:0] osc_step [VOICES];
    logic [2:0]            osc_shape [VOICES];
    logic [15:0]           osc_gain [VOICES];
    logic [31:0]           noise_reg;
    logic [PHASE_BITS-1:0] step_table [128];
    logic [15:0]           gain_table [256];
    logic signed [15:0]    sine_table [SINE_TABLE_DEPTH];

    mix_word_t   pending_mix [$];
    voice_word_t send_queue [$];
    stim_row_t   directed [$];
    int          mismatches;
    int          ticks_sent;
    int          sets_sent;
    int          mixes_seen;
    longint      cycle_count;

    logic        long_hold_req;
    logic        long_hold_done;

    function automatic logic [63:0] qsine(logic [63:0] t);
        logic [63:0] t2;
        logic [63:0] p;
        logic [63:0] q;
        t2 = (t * t) >> 30;
        p = 64'd172273;
        p = 64'd5026995 - ((p * t2) >> 30);
        p = 64'd85569306 - ((p * t2) >> 30);
        p = 64'd693598668 - ((p * t2) >> 30);
        p = 64'd1686629713 - ((p * t2) >> 30);
        q = (((p * t) >> 30) + 64'd16384) >> 15;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return q;
    endfunction

    task automatic fill_tables();
        logic [63:0] hz [12];
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] g;
        logic [63:0] q;
        logic [63:0] a;
        logic [63:0] u;
        logic [63:0] s;
        hz = '{64'd17145893, 64'd18165441, 64'd19245614, 64'd20390018,
               64'd21602472, 64'd22887021, 64'd24247954, 64'd25689813,
               64'd27217409, 64'd28835840, 64'd30550508, 64'd32367136};
        den = 64'd65536 * 64'd48000;
        for (int n = 0; n < 128; n++) begin
            num = hz[n % 12] << (PHASE_BITS + n / 12 - 5);
            step_table[n] = PHASE_BITS'((num + den / 2) / den);
        end
        g = 64'd1 << 30;
        for (int v = 255; v >= 1; v--) begin
            q = (g + 64'd16384) >> 15;
            gain_table[v] = (q > 64'd32767) ? 16'd32767 : q[15:0];
            g = (g * 64'd1045045415 + (64'd1 << 29)) >> 30;
        end
        gain_table[0] = 16'd0;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            a = (64'(i) << 32) / 64'(SINE_TABLE_DEPTH);
            u = a & 64'h3FFF_FFFF;
            s = qsine(a[30] ? ((64'd1 << 30) - u) : u);
            sine_table[i] = a[31] ? -$signed(s[15:0]) : $signed(s[15:0]);
        end
    endtask

    task automatic clear_voices();
        for (int v = 0; v < VOICES; v++) begin
            osc_phase[v] = '0;
            osc_on[v] = 1'b0;
            osc_step[v] = '0;
            osc_shape[v] = '0;
            osc_gain[v] = '0;
        end
        noise_reg = 32'h0000_ACE1;
    endtask

    function automatic longint osc_wave(int v);
        longint p16;
        longint w;
        p16 = longint'(osc_phase[v] >> (PHASE_BITS - 16));
        case (osc_shape[v])
            WAVE_SINE: begin
                w = sine_table[(64'(osc_phase[v]) * SINE_TABLE_DEPTH) >> PHASE_BITS];
            end
            WAVE_SAW: begin
                w = p16 - 32768;
            end
            WAVE_SQUARE: begin
                w = (p16 < 32768) ? 32767 : -32768;
            end
            WAVE_TRIANGLE: begin
                w = (p16 < 32768) ? (2 * p16 - 32768) : (98304 - 2 * p16);
                if (w > 32767) w = 32767;
                if (w < -32768) w = -32768;
            end
            WAVE_NOISE: begin
                noise_reg = (noise_reg >> 1) ^ (noise_reg[0] ? 32'h8020_0003 : 32'h0);
                w = longint'(noise_reg[31:16]) - 32768;
            end
            default: begin
                w = 0;
            end
        endcase
        return w;
    endfunction

    task automatic predict_mix(input voice_word_t w);
        longint acc;
        longint mag;
        longint den;
        longint q;
        int cnt;
        mix_word_t r;
        acc = 0;
        cnt = 0;
        if (w.req_type == REQ_SET) begin
            if (!w.active) begin
                osc_on[w.voice] = 1'b0;
            end else begin
                if (!osc_on[w.voice]) osc_phase[w.voice] = '0;
                osc_on[w.voice] = 1'b1;
                osc_step[w.voice] = step_table[w.midi_note];
                osc_shape[w.voice] = w.waveform;
                osc_gain[w.voice] = gain_table[w.volume];
            end
        end else begin
            for (int v = 0; v < VOICES; v++) begin
                if (osc_on[v]) begin
                    acc += longint'(osc_gain[v]) * osc_wave(v);
                    osc_phase[v] = osc_phase[v] + osc_step[v];
                    cnt++;
                end
            end
            q = 0;
            if (cnt != 0) begin
                mag = (acc < 0) ? -acc : acc;
                den = cnt * 32768;
                q = (mag + den / 2) / den;
                if (q > 32768) q = 32768;
                q = (acc < 0) ? -q : q;
                if (q > 32767) q = 32767;
            end
            r.sample = q[15:0];
            r.voices_active = cnt[4:0];
            pending_mix = {pending_mix, r};
        end
    endtask

    function automatic voice_word_t set_word(int v, int on, int note, int wave, int vol);
        voice_word_t w;
        w.req_type = REQ_SET;
        w.voice = v[3:0];
        w.active = on[0];
        w.midi_note = note[6:0];
        w.waveform = wave[2:0];
        w.volume = vol[7:0];
        return w;
    endfunction

    function automatic voice_word_t tick_word();
        voice_word_t w;
        w = voice_word_t'($urandom);
        w.req_type = REQ_TICK;
        return w;
    endfunction

    function automatic voice_word_t random_word();
        voice_word_t w;
        int sel;
        sel = $urandom_range(0, 99);
        w = voice_word_t'($urandom);
        if (sel < 45) begin
            w.req_type = REQ_TICK;
        end else begin
            w.req_type = REQ_SET;
            if (sel < 85) begin
                w.active = 1'b1;
                w.waveform = 3'($urandom_range(0, 4));
            end
        end
        return w;
    endfunction

    task automatic add_row(input voice_word_t w, input logic known_ok,
                           input int smp, input int cnt);
        stim_row_t r;
        r.word = w;
        r.has_known = known_ok;
        r.known.sample = smp[15:0];
        r.known.voices_active = cnt[4:0];
        directed = {directed, r};
    endtask

    task automatic build_directed();
        add_row(tick_word(), 1'b1, 0, 0);
        add_row(set_word(0, 1, 0, WAVE_SQUARE, 255), 1'b0, 0, 0);
        add_row(tick_word(), 1'b1, 32766, 1);
        add_row(set_word(0, 1, 127, WAVE_SAW, 255), 1'b0, 0, 0);
        add_row(tick_word(), 1'b0, 0, 0);
        add_row(set_word(0, 0, 127, 7, 255), 1'b0, 0, 0);
        add_row(tick_word(), 1'b1, 0, 0);
        add_row(set_word(1, 1, 69, WAVE_SINE, 0), 1'b0, 0, 0);
        add_row(tick_word(), 1'b1, 0, 1);
        add_row(set_word(2, 1, 60, 5, 200), 1'b0, 0, 0);
        add_row(set_word(3, 1, 100, 7, 1), 1'b0, 0, 0);
        add_row(tick_word(), 1'b1, 0, 3);
        add_row(set_word(4, 1, 69, WAVE_TRIANGLE, 255), 1'b0, 0, 0);
        add_row(set_word(5, 1, 127, WAVE_NOISE, 128), 1'b0, 0, 0);
        add_row(set_word(15, 1, 0, WAVE_SINE, 255), 1'b0, 0, 0);
        add_row(tick_word(), 1'b0, 0, 0);
        add_row(tick_word(), 1'b0, 0, 0);
        add_row(set_word(4, 1, 40, WAVE_SAW, 90), 1'b0, 0, 0);
        add_row(tick_word(), 1'b0, 0, 0);
        add_row(set_word(0, 1, 127, WAVE_NOISE, 255), 1'b0, 0, 0);
        add_row(tick_word(), 1'b0, 0, 0);
        for (int v = 0; v < VOICES; v++) begin
            add_row(set_word(v, 0, 0, 0, 0), 1'b0, 0, 0);
        end
        add_row(tick_word(), 1'b1, 0, 0);
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        mix_word_t want;
        if (aresetn && m_valid && m_ready) begin
            mixes_seen <= mixes_seen + 1;
            if (pending_mix.size() == 0) begin
                if (mismatches < 10) begin
                    $display("Unexpected mix word: sample %0d voices %0d",
                             m_sample, m_voices_active);
                end
                mismatches <= mismatches + 1;
            end else begin
                want = pending_mix.pop_front();
                if (m_sample !== want.sample || m_voices_active !== want.voices_active) begin
                    if (mismatches < 10) begin
                        $display("Mix word %0d: expected sample %0d voices %0d, got %0d %0d",
                                 mixes_seen, want.sample, want.voices_active,
                                 m_sample, m_voices_active);
                    end
                    mismatches <= mismatches + 1;
                end
            end
        end
    end

    initial begin
        int stall_left;
        int hold_left;
        m_ready = 1'b0;
        long_hold_done = 1'b0;
        stall_left = 0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (long_hold_req && !long_hold_done) begin
                m_ready <= 1'b0;
                for (hold_left = 1500; hold_left > 0; hold_left--) begin
                    @(posedge aclk);
                end
                long_hold_done = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ((cycle_count / 3000) % 3 != 0 && $urandom_range(0, 9) == 0) begin
                    stall_left = $urandom_range(1, 60);
                end
            end
        end
    end

    initial begin
        voice_word_t w;
        int burst;
        int idx;
        logic known_ok;
        mix_word_t known;
        s_valid = 1'b0;
        {s_req_type, s_voice, s_active, s_midi_note, s_waveform, s_volume} = '0;
        aresetn = 1'b0;
        cycle_count = 0;
        mismatches = 0;
        mixes_seen = 0;
        ticks_sent = 0;
        sets_sent = 0;
        long_hold_req = 1'b0;
        fill_tables();
        clear_voices();
        build_directed();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idx = 0;
        burst = 0;
        while (idx < directed.size() + RANDOM_WORDS) begin
            if (idx < directed.size()) begin
                w = directed[idx].word;
                known_ok = directed[idx].has_known;
                known = directed[idx].known;
            end else begin
                w = random_word();
                known_ok = 1'b0;
            end
            if (idx == directed.size() + 300) long_hold_req = 1'b1;
            if (burst == 0) begin
                burst = $urandom_range(1, 20);
                if ($urandom_range(0, 2) != 0) begin
                    s_valid <= 1'b0;
                    repeat ($urandom_range(1, 50)) @(posedge aclk);
                end
            end
            burst--;
            s_valid <= 1'b1;
            {s_req_type, s_voice, s_active, s_midi_note, s_waveform, s_volume} <= w;
            @(posedge aclk iff s_ready);
            predict_mix(w);
            if (w.req_type == REQ_TICK) ticks_sent++;
            else sets_sent++;
            if (known_ok && pending_mix.size() != 0 &&
                pending_mix[$] !== known) begin
                if (mismatches < 10) begin
                    $display("Directed row %0d: predictor gives %0d %0d, row says %0d %0d",
                             idx, pending_mix[$].sample, pending_mix[$].voices_active,
                             known.sample, known.voices_active);
                end
                mismatches++;
            end
            idx++;
        end
        s_valid <= 1'b0;
        while (pending_mix.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("Sent %0d tick words and %0d voice-set words, checked %0d mixes,",
                 ticks_sent, sets_sent, mixes_seen);
        $display("including a long output stall with a full input side.");
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches.", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
